// ===== sv/pks_pkg.sv =====
// pks_pkg: control word layout and microprogram for the pancake sorter
`default_nettype none

package pks_pkg;

  localparam int PKS_MAX_ITEMS = 64;
  localparam int PKS_DATA_W    = 32;
  localparam int PKS_PC_W      = 5;

  typedef logic [PKS_PC_W-1:0] pc_t;

  // read address source
  typedef enum logic [1:0] {
    RA_ZERO,
    RA_IDX,
    RA_LO,
    RA_HI
  } rd_addr_t;

  // write port source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_IN,
    WR_LO,
    WR_HI
  } wr_sel_t;

  // datapath register operation
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LD_N,
    OP_SCAN_INIT,
    OP_LD_BEST,
    OP_SCAN,
    OP_FLIP1_INIT,
    OP_LD_TMP,
    OP_STEP,
    OP_FLIP2_INIT,
    OP_DEC_N,
    OP_EMIT_INIT,
    OP_EMIT,
    OP_CLEAR
  } op_t;

  // jump condition, taken -> target, else next step
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NOT_GO,
    JC_N_LE1,
    JC_SCAN_MORE,
    JC_BEST_END,
    JC_LO_GE_HI,
    JC_EMIT_MORE
  } jcond_t;

  typedef struct packed {
    op_t      op;
    rd_addr_t rd;
    wr_sel_t  wr;
    jcond_t   jc;
    pc_t      target;
  } ctrl_word_t;

  // step addresses
  localparam pc_t S_IDLE   = 5'd0;
  localparam pc_t S_SINIT  = 5'd1;
  localparam pc_t S_CHKN   = 5'd2;
  localparam pc_t S_LDBEST = 5'd3;
  localparam pc_t S_SCAN   = 5'd4;
  localparam pc_t S_DECIDE = 5'd5;
  localparam pc_t S_F1T    = 5'd6;
  localparam pc_t S_F1H    = 5'd7;
  localparam pc_t S_F1WL   = 5'd8;
  localparam pc_t S_F1WH   = 5'd9;
  localparam pc_t S_F2I    = 5'd10;
  localparam pc_t S_F2T    = 5'd11;
  localparam pc_t S_F2H    = 5'd12;
  localparam pc_t S_F2WL   = 5'd13;
  localparam pc_t S_F2WH   = 5'd14;
  localparam pc_t S_DECN   = 5'd15;
  localparam pc_t S_EINIT  = 5'd16;
  localparam pc_t S_EOUT   = 5'd17;
  localparam pc_t S_EDONE  = 5'd18;

  // microprogram rom
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t cw;
    case (pc)
      S_IDLE:   cw = '{OP_ACCEPT,     RA_ZERO, WR_IN,   JC_NOT_GO,    S_IDLE};
      S_SINIT:  cw = '{OP_LD_N,       RA_ZERO, WR_NONE, JC_NEXT,      S_IDLE};
      S_CHKN:   cw = '{OP_SCAN_INIT,  RA_ZERO, WR_NONE, JC_N_LE1,     S_EINIT};
      S_LDBEST: cw = '{OP_LD_BEST,    RA_IDX,  WR_NONE, JC_NEXT,      S_IDLE};
      S_SCAN:   cw = '{OP_SCAN,       RA_IDX,  WR_NONE, JC_SCAN_MORE, S_SCAN};
      S_DECIDE: cw = '{OP_FLIP1_INIT, RA_ZERO, WR_NONE, JC_BEST_END,  S_DECN};
      S_F1T:    cw = '{OP_NOP,        RA_LO,   WR_NONE, JC_LO_GE_HI,  S_F2I};
      S_F1H:    cw = '{OP_LD_TMP,     RA_HI,   WR_NONE, JC_NEXT,      S_IDLE};
      S_F1WL:   cw = '{OP_NOP,        RA_ZERO, WR_LO,   JC_NEXT,      S_IDLE};
      S_F1WH:   cw = '{OP_STEP,       RA_ZERO, WR_HI,   JC_ALWAYS,    S_F1T};
      S_F2I:    cw = '{OP_FLIP2_INIT, RA_ZERO, WR_NONE, JC_NEXT,      S_IDLE};
      S_F2T:    cw = '{OP_NOP,        RA_LO,   WR_NONE, JC_LO_GE_HI,  S_DECN};
      S_F2H:    cw = '{OP_LD_TMP,     RA_HI,   WR_NONE, JC_NEXT,      S_IDLE};
      S_F2WL:   cw = '{OP_NOP,        RA_ZERO, WR_LO,   JC_NEXT,      S_IDLE};
      S_F2WH:   cw = '{OP_STEP,       RA_ZERO, WR_HI,   JC_ALWAYS,    S_F2T};
      S_DECN:   cw = '{OP_DEC_N,      RA_ZERO, WR_NONE, JC_ALWAYS,    S_CHKN};
      S_EINIT:  cw = '{OP_EMIT_INIT,  RA_ZERO, WR_NONE, JC_NEXT,      S_IDLE};
      S_EOUT:   cw = '{OP_EMIT,       RA_IDX,  WR_NONE, JC_EMIT_MORE, S_EOUT};
      S_EDONE:  cw = '{OP_CLEAR,      RA_ZERO, WR_NONE, JC_ALWAYS,    S_IDLE};
      default:  cw = '{OP_NOP,        RA_ZERO, WR_NONE, JC_ALWAYS,    S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pancake_sorter.sv =====
// pancake_sorter: collects signed words, sorts them by prefix flips, streams them out
//
//   channel   ports                                     handshake
//   -------   ----------------------------------------  -----------------------------
//   input     in_value, in_last_item                    start && !busy
//   result    out_sorted_value, out_last_out            out_valid, one cycle, no stall
//
// loading accepts one transaction per cycle while busy is low; a transaction with
// in_last_item set starts the sort. for each prefix of size n (from the set size down
// to 2) the sequencer scans for the prefix maximum, flips the prefix up to the maximum
// (first flip) and then the whole prefix (second flip), skipping both when the maximum
// already ends the prefix, and shrinks the prefix; each flip swaps elements pairwise
// from both ends inward. the scan and the flips all share the single read port of the
// element ram. busy is high from the last transaction until the final result. rst_n is
// synchronous and clears the step counter, element count and result strobe; the element
// ram is not cleared. results cannot be stalled by the receiver.
`default_nettype none

module pancake_sorter
  import pks_pkg::*;
#(
  parameter int MAX_ITEMS = PKS_MAX_ITEMS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [PKS_DATA_W-1:0] in_value,
  input  wire logic                         in_last_item,
  output logic                              out_valid,
  output logic signed      [PKS_DATA_W-1:0] out_sorted_value,
  output logic                              out_last_out
);

  localparam int AW = $clog2(MAX_ITEMS);     // element address width
  localparam int CW = $clog2(MAX_ITEMS + 1); // count width, holds MAX_ITEMS itself

  // sequencer
  pc_t        pc_r, pc_nxt;
  ctrl_word_t cw;

  // datapath registers
  logic [CW-1:0]         cnt_r, cnt_nxt;      // elements held
  logic [CW-1:0]         n_r, n_nxt;          // current prefix size
  logic [CW-1:0]         i_r, i_nxt;          // scan / emit index, one ahead of rdata
  logic [AW-1:0]         best_r, best_nxt;    // position of prefix maximum
  logic [PKS_DATA_W-1:0] bestv_r, bestv_nxt;  // value of prefix maximum
  logic [AW-1:0]         lo_r, lo_nxt;        // flip pointers
  logic [AW-1:0]         hi_r, hi_nxt;
  logic [PKS_DATA_W-1:0] tmp_r, tmp_nxt;      // holds lower element of a swap

  logic                  out_valid_r, out_valid_nxt;
  logic [PKS_DATA_W-1:0] out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;

  // ram port signals
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [PKS_DATA_W-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [PKS_DATA_W-1:0] ram_rdata;

  logic accept;
  logic room;
  logic take;

  assign cw     = ucode(pc_r);
  assign busy   = (pc_r != S_IDLE);
  assign accept = start && !busy;
  assign room   = (cnt_r < CW'(MAX_ITEMS));

  // element store
  pks_ram #(
    .WIDTH(PKS_DATA_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // read address select
  always_comb begin
    case (cw.rd)
      RA_ZERO: ram_raddr = '0;
      RA_IDX:  ram_raddr = i_r[AW-1:0];
      RA_LO:   ram_raddr = lo_r;
      RA_HI:   ram_raddr = hi_r;
      default: ram_raddr = '0;
    endcase
  end

  // write port select; a full store drops incoming values
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = in_value;
    case (cw.wr)
      WR_IN: begin
        ram_we = accept && room;
      end
      WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = ram_rdata;
      end
      WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = tmp_r;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // jump condition
  always_comb begin
    case (cw.jc)
      JC_NEXT:      take = 1'b0;
      JC_ALWAYS:    take = 1'b1;
      JC_NOT_GO:    take = !(accept && in_last_item);
      JC_N_LE1:     take = (n_r <= CW'(1));
      JC_SCAN_MORE: take = (i_r != n_r);
      JC_BEST_END:  take = (CW'(best_r) == (n_r - CW'(1)));
      JC_LO_GE_HI:  take = (lo_r >= hi_r);
      JC_EMIT_MORE: take = (i_r != cnt_r);
      default:      take = 1'b1;
    endcase
    pc_nxt = take ? cw.target : pc_r + PKS_PC_W'(1);
  end

  // datapath operations
  always_comb begin
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    best_nxt      = best_r;
    bestv_nxt     = bestv_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    case (cw.op)
      OP_ACCEPT: begin
        if (accept && room) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      OP_LD_N: begin
        n_nxt = cnt_r;
      end
      OP_SCAN_INIT: begin
        // element 0 is being read, the scan begins at element 1
        i_nxt    = CW'(1);
        best_nxt = '0;
      end
      OP_LD_BEST: begin
        bestv_nxt = ram_rdata;
        i_nxt     = i_r + CW'(1);
      end
      OP_SCAN: begin
        // rdata holds element i-1; strict compare keeps the first maximum
        if ($signed(ram_rdata) > $signed(bestv_r)) begin
          bestv_nxt = ram_rdata;
          best_nxt  = AW'(i_r - CW'(1));
        end
        i_nxt = i_r + CW'(1);
      end
      OP_FLIP1_INIT: begin
        lo_nxt = '0;
        hi_nxt = best_r;
      end
      OP_LD_TMP: begin
        tmp_nxt = ram_rdata;
      end
      OP_STEP: begin
        lo_nxt = lo_r + AW'(1);
        hi_nxt = hi_r - AW'(1);
      end
      OP_FLIP2_INIT: begin
        lo_nxt = '0;
        hi_nxt = AW'(n_r - CW'(1));
      end
      OP_DEC_N: begin
        n_nxt = n_r - CW'(1);
      end
      OP_EMIT_INIT: begin
        i_nxt = CW'(1);
      end
      OP_EMIT: begin
        // rdata holds element i-1
        out_valid_nxt = 1'b1;
        out_value_nxt = ram_rdata;
        out_last_nxt  = (i_r == cnt_r);
        i_nxt         = i_r + CW'(1);
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    best_r      <= best_nxt;
    bestv_r     <= bestv_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    tmp_r       <= tmp_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = $signed(out_value_r);
  assign out_last_out     = out_valid_r && out_last_r;

  // the final result of a set is on the ports while the count is being cleared
  a_last_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_EDONE) |-> (out_valid && out_last_out))
    else $error("final result not shown when the set completes");

  // a final result ends the burst
  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_out) |=> !out_valid)
    else $error("result strobe after the final result");

  // swap writes only happen with the flip pointers still apart
  a_swap_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_F1WL || pc_r == S_F1WH || pc_r == S_F2WL || pc_r == S_F2WH)
      |-> (lo_r < hi_r))
    else $error("swap with crossed flip pointers");

  // a full store drops further values
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_last_item && cnt_r == CW'(MAX_ITEMS)) |=> (cnt_r == CW'(MAX_ITEMS)))
    else $error("element count moved past a full store");

endmodule

`default_nettype wire

// ===== sv/pks_ram.sv =====
// pks_ram: generic single write, single read ram with registered read
`default_nettype none

module pks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
